// ===== sv/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable min priority queue package
// Shared widths, codes and word types for the sorted cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 5;

  localparam logic       REQ_INSERT  = 1'b0;
  localparam logic       REQ_REMOVE  = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [15:0] out_priority;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t item;
  } cell_ctrl_t;

  // The reported occupancy is the entry count masked to its low bits.
  function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
    logic [31:0] ext;
    ext = 32'(cnt);
    return ext[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/stable_min_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Stable min priority queue core
// Sorted chain of DEPTH cells; lower priority first, equal priorities in order.
// ----------------------------------------------------------------------------
// The result word is registered and appears in the cycle after the request word is taken.
// Throughput: one request word per cycle; busy stays low, since every cell
// compares and shifts in the same cycle.
// Reset clears the entry count and the result strobe; the cells hold no
// reset value and are only read below the count.
`default_nettype none

module stable_min_priority_queue_core
  import smpq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      result_valid_o,
  output rsp_t      rsp_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             valid_q;
  rsp_t             rsp_q, rsp_d;
  logic             full, empty, do_ins, do_rem, is_ins, is_rem;
  cell_ctrl_t       ctrl;
  logic             keep [DEPTH];
  entry_t           entries [DEPTH];

  assign busy   = 1'b0;
  assign is_ins = start && (req_i.req_type == REQ_INSERT);
  assign is_rem = start && (req_i.req_type == REQ_REMOVE);
  assign full   = count_q == CNT_W'(DEPTH);
  assign empty  = count_q == '0;
  assign do_ins = is_ins && !full;
  assign do_rem = is_rem && !empty;

  assign ctrl.insert         = do_ins;
  assign ctrl.remove         = do_rem;
  assign ctrl.item.value     = req_i.item_value;
  assign ctrl.item.prio      = req_i.item_priority;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    smpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .idx_i        (IDX_W'(i)),
      .count_i      (count_q),
      .left_keep_i  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
      .left_entry_i (entries[(i == 0) ? 0 : i - 1]),
      .right_entry_i(entries[(i == DEPTH - 1) ? i : i + 1]),
      .keep_o       (keep[i]),
      .entry_o      (entries[i])
    );
  end

  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_rem) begin
      count_d = count_q - 1'b1;
    end
    priority if (do_ins) begin
      rsp_d.status = ST_INSERTED;
    end else if (do_rem) begin
      rsp_d.status       = ST_REMOVED;
      rsp_d.out_value    = entries[0].value;
      rsp_d.out_priority = entries[0].prio;
    end else if (is_rem) begin
      rsp_d.status = ST_EMPTY;
    end else begin
      rsp_d.status = ST_FULL;
    end
    rsp_d.occupancy = occ_of(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> result_valid_o)
    else $error("Accepted word produced no result word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the queue depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rem |=> rsp_q.status == ST_REMOVED && count_q + 1'b1 == $past(count_q))
    else $error("Removal did not report or decrement correctly.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CNT_W'(2) |-> entries[0].prio <= entries[1].prio)
    else $error("Head entries are out of priority order.");

endmodule

`default_nettype wire

// ===== sv/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// Stable min priority queue cell
// Holds one entry of the sorted chain and shifts it toward either neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_cell
  import smpq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic             left_keep_i,
  input  wire entry_t           left_entry_i,
  input  wire entry_t           right_entry_i,
  output logic                  keep_o,
  output entry_t                entry_o
);

  entry_t entry_q, entry_d;
  logic   occupied;

  assign occupied = CNT_W'(idx_i) < count_i;
  assign keep_o   = occupied && (entry_q.prio <= ctrl_i.item.prio);
  assign entry_o  = entry_q;

  // An insert keeps entries that go before the new one, places the new one in
  // the first cell that does not keep, and moves the rest one cell down.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? ctrl_i.item : left_entry_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.insert && !keep_o && left_keep_i |=> entry_q == $past(ctrl_i.item))
    else $error("Cell did not take the new entry at its sorted place.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.insert && !ctrl_i.remove |=> $stable(entry_q))
    else $error("Cell entry changed without a queue operation.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.insert && ctrl_i.remove |-> 1'b0)
    else $error("Cell saw insert and remove together.");

endmodule

`default_nettype wire
